FILE: rtl/scsi_pkg.sv
// ----------------------------------------------------------------------------
// scsi_pkg: shared types and constants for the sparse cumulative sum index
// Table geometry, command and status codes, the table entry layout and the
// request format of the shared adder.
// ----------------------------------------------------------------------------
package scsi_pkg;

	localparam int ENTRIES = 1024;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int ALU_W   = 66;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_ROLL  = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NEGATIVE = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [31:0] height;
		logic [62:0] amount;
		logic [63:0] interest;
	} entry_t;

	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] x;
		logic [ALU_W-1:0] y;
	} alu_req_t;

endpackage

FILE: rtl/scsi_store.sv
// ----------------------------------------------------------------------------
// scsi_store: entry table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scsi_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [scsi_pkg::ADDR_W-1:0] waddr,
	input  scsi_pkg::entry_t           wdata,
	input  logic [scsi_pkg::ADDR_W-1:0] raddr,
	output scsi_pkg::entry_t           rdata
);
	import scsi_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/scsi_alu.sv
// ----------------------------------------------------------------------------
// scsi_alu: shared wide adder
// Adds or subtracts two 66-bit operands; used for totals and height compares.
// ----------------------------------------------------------------------------
module scsi_alu (
	input  scsi_pkg::alu_req_t             req,
	output logic [scsi_pkg::ALU_W-1:0]     sum
);
	import scsi_pkg::*;

	logic [ALU_W-1:0] y_eff;

	assign y_eff = req.sub ? ~req.y : req.y;
	assign sum   = req.x + y_eff + {{(ALU_W-1){1'b0}}, req.sub};

endmodule

FILE: rtl/sparse_cumulative_sum_index.sv
// ----------------------------------------------------------------------------
// sparse_cumulative_sum_index: sparse table of running totals by block height
// Push runs an amount adder pass, then an interest pass that decides; pop
// also reloads the entry below from the table when the newest entry goes.
// Rollback and query run k binary-search steps (at most log2(entries stored)+1,
// so 11 for a 1024-entry table), skipped when there is nothing to search;
// each step is one table read and one compare.
// One request at a time: busy stays high until done; results cannot be stalled.
// Reset clears the counts and the cached newest totals; the table itself is
// left undefined and needs no clearing pass.
// ----------------------------------------------------------------------------
module sparse_cumulative_sum_index (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [63:0] amount,
	input  logic [63:0]        interest,
	input  logic [31:0]        height,
	output logic               done,
	output logic [62:0]        total_amount,
	output logic [63:0]        total_interest,
	output logic [31:0]        blocks,
	output logic [31:0]        removed,
	output logic [2:0]         status
);
	import scsi_pkg::*;

	// Sequencer state codes
	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_PUSH_A    = 4'd1;
	localparam logic [3:0] S_PUSH_I    = 4'd2;
	localparam logic [3:0] S_POP       = 4'd3;
	localparam logic [3:0] S_ROLL      = 4'd4;
	localparam logic [3:0] S_QUERY     = 4'd5;
	localparam logic [3:0] S_SRCH_RD   = 4'd6;
	localparam logic [3:0] S_SRCH_CMP  = 4'd7;
	localparam logic [3:0] S_LOAD_RD   = 4'd8;
	localparam logic [3:0] S_LOAD_WAIT = 4'd9;
	localparam logic [3:0] S_QRY_RD    = 4'd10;
	localparam logic [3:0] S_QRY_WAIT  = 4'd11;

	logic [3:0]        state_q;

	// Latched request
	logic [1:0]        cmd_q;
	logic [63:0]       amount_q;
	logic [63:0]       interest_q;
	logic [31:0]       height_q;

	// Architectural counts and the cached newest entry
	logic [CNT_W-1:0]  ec_q;
	logic [31:0]       bc_q;
	logic [62:0]       last_a_q;
	logic [63:0]       last_i_q;
	logic [31:0]       last_h_q;

	// Push scratch: amount sum and its flags from the first adder pass
	logic [62:0]       new_a_q;
	logic              a_ovf_q;
	logic              a_neg_q;

	// Binary search bounds
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  mid_q;
	logic              strict_q;
	logic [CNT_W-1:0]  mid;

	// Result registers
	logic              done_q;
	logic [62:0]       tot_a_q;
	logic [63:0]       tot_i_q;
	logic [31:0]       removed_q;
	logic [2:0]        status_q;

	// Shared adder and table ports
	alu_req_t          alu_req;
	logic [ALU_W-1:0]  alu_sum;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_raddr;
	entry_t            mem_wdata;
	entry_t            mem_rdata;

	// Push decision terms
	logic              push_store;
	logic              i_carry;
	logic              bc_max;
	logic              tbl_full;
	logic              push_ok;
	logic              precedes;

	scsi_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	scsi_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ec_q[ADDR_W-1:0]),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Route operands to the shared adder by sequencer step
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_PUSH_A: begin
				// zero-extended total plus sign-extended amount: sign gives negative,
				// bits 64..63 give overflow past the 63-bit range
				alu_req.x = {3'b000, last_a_q};
				alu_req.y = {{2{amount_q[63]}}, amount_q};
			end
			S_PUSH_I: begin
				alu_req.x = {2'b00, last_i_q};
				alu_req.y = {2'b00, interest_q};
			end
			S_SRCH_CMP: begin
				alu_req.sub = 1'b1;
				if (strict_q) begin
					alu_req.x = {34'd0, mem_rdata.height};
					alu_req.y = {34'd0, height_q};
				end else begin
					alu_req.x = {34'd0, height_q};
					alu_req.y = {34'd0, mem_rdata.height};
				end
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// Strict: entry height below target. Otherwise: target not below entry height.
	assign precedes = strict_q ? alu_sum[ALU_W-1] : !alu_sum[ALU_W-1];

	assign push_store = (amount_q != 64'd0) || (interest_q != 64'd0);
	assign i_carry    = alu_sum[64];
	assign bc_max     = (bc_q == 32'hFFFF_FFFF);
	assign tbl_full   = (ec_q == CNT_W'(ENTRIES));
	assign push_ok    = !a_ovf_q && !i_carry && !bc_max && !a_neg_q &&
		!(push_store && tbl_full);

	assign mem_we           = (state_q == S_PUSH_I) && push_ok && push_store;
	assign mem_wdata.height   = bc_q;
	assign mem_wdata.amount   = new_a_q;
	assign mem_wdata.interest = alu_sum[63:0];

	// Table read address: search midpoint, newest entry, or query hit
	always_comb begin
		case (state_q)
			S_SRCH_RD: mem_raddr = mid[ADDR_W-1:0];
			S_LOAD_RD: mem_raddr = ec_q[ADDR_W-1:0] - ADDR_W'(1);
			S_QRY_RD:  mem_raddr = lo_q[ADDR_W-1:0] - ADDR_W'(1);
			default:   mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= CMD_PUSH;
			amount_q   <= '0;
			interest_q <= '0;
			height_q   <= '0;
			ec_q       <= '0;
			bc_q       <= '0;
			last_a_q   <= '0;
			last_i_q   <= '0;
			last_h_q   <= '0;
			new_a_q    <= '0;
			a_ovf_q    <= 1'b0;
			a_neg_q    <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			strict_q   <= 1'b0;
			done_q     <= 1'b0;
			tot_a_q    <= '0;
			tot_i_q    <= '0;
			removed_q  <= '0;
			status_q   <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q      <= cmd;
						amount_q   <= amount;
						interest_q <= interest;
						height_q   <= height;
						removed_q  <= '0;
						case (cmd)
							CMD_PUSH: state_q <= S_PUSH_A;
							CMD_POP:  state_q <= S_POP;
							CMD_ROLL: state_q <= S_ROLL;
							default:  state_q <= S_QUERY;
						endcase
					end
				end
				S_PUSH_A: begin
					// Hold the amount sum and its flags for the decision step
					new_a_q <= alu_sum[62:0];
					a_neg_q <= alu_sum[ALU_W-1];
					a_ovf_q <= !alu_sum[ALU_W-1] && (alu_sum[64] || alu_sum[63]);
					state_q <= S_PUSH_I;
				end
				S_PUSH_I: begin
					// Checks in priority order; an error leaves the counts and the cached newest entry unchanged
					tot_a_q  <= last_a_q;
					tot_i_q  <= last_i_q;
					if (a_ovf_q || i_carry || bc_max) begin
						status_q <= ST_OVERFLOW;
					end else if (a_neg_q) begin
						status_q <= ST_NEGATIVE;
					end else if (push_store && tbl_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
						bc_q     <= bc_q + 32'd1;
						if (push_store) begin
							ec_q     <= ec_q + CNT_W'(1);
							last_a_q <= new_a_q;
							last_i_q <= alu_sum[63:0];
							last_h_q <= bc_q;
							tot_a_q  <= new_a_q;
							tot_i_q  <= alu_sum[63:0];
						end
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_POP: begin
					if (bc_q == 32'd0) begin
						status_q <= ST_EMPTY;
						tot_a_q  <= last_a_q;
						tot_i_q  <= last_i_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						status_q <= ST_OK;
						bc_q     <= bc_q - 32'd1;
						if ((ec_q != '0) && (last_h_q == bc_q - 32'd1)) begin
							// Drop the newest entry, then reload the one below it
							ec_q <= ec_q - CNT_W'(1);
							if (ec_q == CNT_W'(1)) begin
								last_a_q <= '0;
								last_i_q <= '0;
								last_h_q <= '0;
								tot_a_q  <= '0;
								tot_i_q  <= '0;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_LOAD_RD;
							end
						end else begin
							tot_a_q <= last_a_q;
							tot_i_q <= last_i_q;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_ROLL: begin
					status_q <= ST_OK;
					if (height_q >= bc_q) begin
						tot_a_q <= last_a_q;
						tot_i_q <= last_i_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lo_q     <= '0;
						hi_q     <= ec_q;
						strict_q <= 1'b1;
						state_q  <= S_SRCH_RD;
					end
				end
				S_QUERY: begin
					status_q <= ST_OK;
					if (bc_q == 32'd0) begin
						tot_a_q <= '0;
						tot_i_q <= '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lo_q     <= '0;
						hi_q     <= ec_q;
						strict_q <= 1'b0;
						state_q  <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						// Read the midpoint; compare next cycle
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else if (cmd_q == CMD_ROLL) begin
						// lo is the count of entries below the rollback height
						ec_q      <= lo_q;
						removed_q <= bc_q - height_q;
						bc_q      <= height_q;
						if (lo_q == '0) begin
							last_a_q <= '0;
							last_i_q <= '0;
							last_h_q <= '0;
							tot_a_q  <= '0;
							tot_i_q  <= '0;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_LOAD_RD;
						end
					end else begin
						if (lo_q == '0) begin
							tot_a_q <= '0;
							tot_i_q <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_QRY_RD;
						end
					end
				end
				S_SRCH_CMP: begin
					if (precedes) begin
						lo_q <= mid_q + CNT_W'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH_RD;
				end
				S_LOAD_RD: begin
					state_q <= S_LOAD_WAIT;
				end
				S_LOAD_WAIT: begin
					// Refresh the newest-entry cache from the table
					last_a_q <= mem_rdata.amount;
					last_i_q <= mem_rdata.interest;
					last_h_q <= mem_rdata.height;
					tot_a_q  <= mem_rdata.amount;
					tot_i_q  <= mem_rdata.interest;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_QRY_RD: begin
					state_q <= S_QRY_WAIT;
				end
				S_QRY_WAIT: begin
					tot_a_q <= mem_rdata.amount;
					tot_i_q <= mem_rdata.interest;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign total_amount   = tot_a_q;
	assign total_interest = tot_i_q;
	assign blocks         = bc_q;
	assign removed        = removed_q;
	assign status         = status_q;

	// A result only ever appears once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// The entry count never passes the table depth
	a_ec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ec_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table depth");

	// An accepted request always occupies the sequencer before its result appears
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start");

	// Only a push can report a full table
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (cmd_q == CMD_PUSH))
		else $error("table full reported for non-push request");

endmodule
